// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each use sits on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ttfr_pkg.sv -----
package ttfr_pkg;

  localparam int unsigned NUM_PAYLOAD = 10;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [7:0] byte_t;

  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_A  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_B  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRAILER = 2'd3;

  localparam byte_t HEADER_RST  = 8'h2C;
  localparam byte_t TYPE_A_RST  = 8'h04;
  localparam byte_t TYPE_B_RST  = 8'h05;
  localparam byte_t TRAILER_RST = 8'h5B;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TYPE    = 3'd1,
    PH_DATA_A  = 3'd2,
    PH_TRAILER = 3'd3,
    PH_DATA_B  = 3'd4
  } phase_t;

  typedef struct packed {
    byte_t header;
    byte_t type_a;
    byte_t type_b;
    byte_t trailer;
  } cfg_t;

  typedef struct packed {
    logic                        kind;
    logic [NUM_PAYLOAD-1:0][7:0] payload;
  } res_t;

  typedef struct packed {
    phase_t phase;
    logic   busy;
  } sts_t;

endpackage

// ----- design/ttfr_cfg_regs.sv -----
module ttfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ttfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  ttfr_pkg::byte_t                cfg_wdata,
  output ttfr_pkg::cfg_t                 cfg
);

  ttfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header  <= ttfr_pkg::HEADER_RST;
      cfg_r.type_a  <= ttfr_pkg::TYPE_A_RST;
      cfg_r.type_b  <= ttfr_pkg::TYPE_B_RST;
      cfg_r.trailer <= ttfr_pkg::TRAILER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttfr_pkg::CFG_HEADER:  cfg_r.header  <= cfg_wdata;
        ttfr_pkg::CFG_TYPE_A:  cfg_r.type_a  <= cfg_wdata;
        ttfr_pkg::CFG_TYPE_B:  cfg_r.type_b  <= cfg_wdata;
        ttfr_pkg::CFG_TRAILER: cfg_r.trailer <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/ttfr_parser.sv -----
module ttfr_parser #(
  parameter int unsigned PAYLOAD_LEN = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ttfr_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  ttfr_pkg::byte_t in_rx_byte,
  output logic            in_stall,
  input  logic            adv,
  output logic            res_valid,
  output ttfr_pkg::res_t  res,
  output ttfr_pkg::sts_t  sts
);

  localparam int unsigned FILL_W = $clog2(PAYLOAD_LEN + 1);

  logic                vld_r;
  ttfr_pkg::byte_t     byte_r;
  ttfr_pkg::phase_t    phase_r, phase_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt, fill_inc;
  logic                kind_r, kind_nxt;
  ttfr_pkg::byte_t     store_r [PAYLOAD_LEN];
  logic                shift;
  logic                fire;
  logic                in_acc;

  assign fire     = vld_r && adv;
  assign in_stall = vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;
  assign fill_inc = fill_r + FILL_W'(1);

  // Input register: hold the byte until the result side can take its outcome.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_acc) begin
      vld_r <= 1'b1;
    end else if (fire) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_r <= in_rx_byte;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    kind_nxt  = kind_r;
    shift     = 1'b0;
    res_valid = 1'b0;
    if (fire) begin
      unique case (phase_r) inside
        ttfr_pkg::PH_HEADER: begin
          if (byte_r == cfg.header) begin
            phase_nxt = ttfr_pkg::PH_TYPE;
            fill_nxt  = '0;
          end
        end
        ttfr_pkg::PH_TYPE: begin
          // kind A wins when both type values match
          if (byte_r == cfg.type_a) begin
            phase_nxt = ttfr_pkg::PH_DATA_A;
            kind_nxt  = 1'b0;
          end else if (byte_r == cfg.type_b) begin
            phase_nxt = ttfr_pkg::PH_DATA_B;
            kind_nxt  = 1'b1;
          end
        end
        ttfr_pkg::PH_DATA_A, ttfr_pkg::PH_DATA_B: begin
          shift    = 1'b1;
          fill_nxt = fill_inc;
          if (fill_inc == FILL_W'(PAYLOAD_LEN)) begin
            phase_nxt = ttfr_pkg::PH_TRAILER;
          end
        end
        ttfr_pkg::PH_TRAILER: begin
          if (byte_r == cfg.trailer) begin
            res_valid = 1'b1;
            phase_nxt = ttfr_pkg::PH_HEADER;
          end
        end
        default: begin
          phase_nxt = ttfr_pkg::PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ttfr_pkg::PH_HEADER;
      fill_r  <= '0;
      kind_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // Payload shifts in at the top, so after a full frame entry 0 is the oldest byte.
  always_ff @(posedge clk) begin
    if (shift) begin
      store_r[PAYLOAD_LEN-1] <= byte_r;
      for (int unsigned k = 0; k + 1 < PAYLOAD_LEN; k++) begin
        store_r[k] <= store_r[k+1];
      end
    end
  end

  assign res.kind = kind_r;

  for (genvar g = 0; g < ttfr_pkg::NUM_PAYLOAD; g++) begin : g_pay
    if (g < PAYLOAD_LEN) begin : g_used
      assign res.payload[g] = store_r[g];
    end else begin : g_zero
      assign res.payload[g] = '0;
    end
  end

  assign sts.phase = phase_r;
  assign sts.busy  = vld_r;

endmodule

// ----- design/ttfr_out_reg.sv -----
module ttfr_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  ttfr_pkg::res_t res,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_stall,
  output ttfr_pkg::res_t out_res
);

  logic           vld_r;
  ttfr_pkg::res_t res_r;

  // Advance whenever the slot is empty or being drained this cycle.
  assign adv = !vld_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

// ----- design/two_type_frame_receiver.sv -----
// Frame receiver for header / type / payload / trailer byte streams.
// Input channel: one received byte per request on in_rx_byte, taken when
// in_valid is high and in_stall is low. Result channel: one request per
// completed frame with out_frame_kind (0 = kind A, 1 = kind B) and the payload
// bytes in arrival order; bytes beyond PAYLOAD_LEN read as zero.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 header,
// 1 type A, 2 type B, 3 trailer); the user must write only while the block
// is idle; the block itself does not enforce this. A trailer byte's result
// passes the input register, then the result register, before it appears on
// the result channel. Throughput: one byte per cycle while in_stall is low,
// set by the single input register feeding the frame tracker.
// Reset: synchronous on rst_n low; registers return to their defaults
// (0x2C, 0x04, 0x05, 0x5B), the tracker waits for a header and both
// stages empty. When the receiver stalls, the result holds and the input
// register keeps taking bytes until it fills; in_stall then rises and
// stays high until the result is taken.
`include "assert_macros.svh"

module two_type_frame_receiver #(
  parameter int unsigned PAYLOAD_LEN = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ttfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_frame_kind,
  output logic [7:0]                     out_payload_byte_0,
  output logic [7:0]                     out_payload_byte_1,
  output logic [7:0]                     out_payload_byte_2,
  output logic [7:0]                     out_payload_byte_3,
  output logic [7:0]                     out_payload_byte_4,
  output logic [7:0]                     out_payload_byte_5,
  output logic [7:0]                     out_payload_byte_6,
  output logic [7:0]                     out_payload_byte_7,
  output logic [7:0]                     out_payload_byte_8,
  output logic [7:0]                     out_payload_byte_9
);

  ttfr_pkg::cfg_t cfg;
  ttfr_pkg::res_t res;
  ttfr_pkg::res_t out_res;
  ttfr_pkg::sts_t sts;
  logic           res_valid;
  logic           adv;

  ttfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ttfr_parser #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .adv        (adv),
    .res_valid  (res_valid),
    .res        (res),
    .sts        (sts)
  );

  ttfr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_frame_kind     = out_res.kind;
  assign out_payload_byte_0 = out_res.payload[0];
  assign out_payload_byte_1 = out_res.payload[1];
  assign out_payload_byte_2 = out_res.payload[2];
  assign out_payload_byte_3 = out_res.payload[3];
  assign out_payload_byte_4 = out_res.payload[4];
  assign out_payload_byte_5 = out_res.payload[5];
  assign out_payload_byte_6 = out_res.payload[6];
  assign out_payload_byte_7 = out_res.payload[7];
  assign out_payload_byte_8 = out_res.payload[8];
  assign out_payload_byte_9 = out_res.payload[9];

  `ASSERT_NOW(a_stall_only_when_blocked, in_stall, sts.busy && out_valid && out_stall, "input stalled while result side free")
  `ASSERT_NEXT(a_result_lands, res_valid, out_valid, "completed frame did not reach the result register")
  `ASSERT_NEXT(a_back_to_header, res_valid, sts.phase == ttfr_pkg::PH_HEADER, "tracker not waiting for header after a frame")

endmodule
